FILE: rtl/tcon_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console package
// Shared item types, command codes, register indexes and the control and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcon_pkg;

  // Command codes of an input item.
  localparam logic [1:0] CmdPrint = 2'd0;
  localparam logic [1:0] CmdClear = 2'd1;
  localparam logic [1:0] CmdRead  = 2'd2;

  // Configuration register indexes and port widths.
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 4;
  localparam logic [CfgIdxW-1:0] CfgFgIdx = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgBgIdx = 1'd1;
  localparam logic [CfgDataW-1:0] FgReset = 4'd15;
  localparam logic [CfgDataW-1:0] BgReset = 4'd0;

  // Character codes.
  localparam logic [7:0] NewlineByte = 8'd10;
  localparam logic [7:0] SpaceByte   = 8'd32;

  // Input item.
  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  symbol;
    logic [10:0] cell_address;
  } tcon_in_t;

  // Result item.
  typedef struct packed {
    logic [10:0] cursor_position;
    logic [15:0] cell_data;
    logic        scrolled;
  } tcon_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap;          // capture the input item
    logic cnt_clr;      // clear the sweep counter
    logic cnt_inc;      // advance the sweep counter
    logic wr_cursor;    // write the printed cell under the cursor
    logic wr_fill;      // write the fill word at the sweep counter
    logic fill_blank;   // fill word is a blank in the current colors
    logic rd_item;      // read the cell named by the item
    logic rd_copy;      // read one row below the sweep counter for a scroll
    logic cur_adv;      // advance the cursor column
    logic cur_newline;  // cursor to column 0 of the next row; the row holds on the last row
    logic cur_home;     // cursor to row 0, column 0
    logic set_scroll;   // mark the item as having scrolled
    logic finish;       // load the result register
  } tcon_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] command;
    logic       is_newline;
    logic       col_last;
    logic       row_last;
    logic       cnt_end;
    logic       cnt_copy_end;
  } tcon_sts_t;

endpackage
`default_nettype wire

FILE: rtl/tcon_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console controller
// State machine that sequences one item at a time: the clearing pass after
// reset, cell writes, reads, the clear sweep and the scroll copy.
// ----------------------------------------------------------------------------
module tcon_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start,
  output logic                busy,
  input  tcon_pkg::tcon_sts_t sts_i,
  output tcon_pkg::tcon_cmd_t cmd_o
);
  import tcon_pkg::*;

  localparam logic [2:0] SInit   = 3'd0;
  localparam logic [2:0] SIdle   = 3'd1;
  localparam logic [2:0] SExec   = 3'd2;
  localparam logic [2:0] SCopy   = 3'd3;
  localparam logic [2:0] SDrain  = 3'd4;
  localparam logic [2:0] SZero   = 3'd5;
  localparam logic [2:0] SClear  = 3'd6;
  localparam logic [2:0] SFinish = 3'd7;

  logic [2:0] state_q, state_d;

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      SInit: begin
        cmd_o.wr_fill = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_end) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (start) begin
          cmd_o.cap     = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          state_d       = SExec;
        end
      end
      SExec: begin
        case (sts_i.command)
          CmdPrint: begin
            state_d = SFinish;
            if (!sts_i.is_newline) begin
              cmd_o.wr_cursor = 1'b1;
            end
            if (sts_i.is_newline || sts_i.col_last) begin
              cmd_o.cur_newline = 1'b1;
              if (sts_i.row_last) begin
                cmd_o.set_scroll = 1'b1;
                state_d          = SCopy;
              end
            end else begin
              cmd_o.cur_adv = 1'b1;
            end
          end
          CmdClear: begin
            cmd_o.cur_home = 1'b1;
            state_d        = SClear;
          end
          CmdRead: begin
            cmd_o.rd_item = 1'b1;
            state_d       = SFinish;
          end
          default: begin
            state_d = SFinish;
          end
        endcase
      end
      SCopy: begin
        cmd_o.rd_copy = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_copy_end) begin
          state_d = SDrain;
        end
      end
      SDrain: begin
        // The last copied word is written in this cycle.
        state_d = SZero;
      end
      SZero: begin
        cmd_o.wr_fill = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_end) begin
          state_d = SFinish;
        end
      end
      SClear: begin
        cmd_o.wr_fill    = 1'b1;
        cmd_o.fill_blank = 1'b1;
        cmd_o.cnt_inc    = 1'b1;
        if (sts_i.cnt_end) begin
          state_d = SFinish;
        end
      end
      SFinish: begin
        cmd_o.finish = 1'b1;
        state_d      = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  assign busy = (state_q != SIdle);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SInit;
    end else begin
      state_q <= state_d;
    end
  end

  // An accepted item always starts in the execute state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle && start) |=> (state_q == SExec))
    else $error("accepted item did not enter execute state");

endmodule
`default_nettype wire

FILE: rtl/tcon_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console datapath
// Screen cell store, cursor, sweep counter, color registers and the result
// register. It acts on commands from the controller and on writes to the color registers.
// ----------------------------------------------------------------------------
module tcon_dp #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  tcon_pkg::tcon_in_t             item_i,
  input  wire                            cfg_we_i,
  input  wire [tcon_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire [tcon_pkg::CfgDataW-1:0]   cfg_data_i,
  input  tcon_pkg::tcon_cmd_t            cmd_i,
  output tcon_pkg::tcon_sts_t            sts_o,
  output logic                           done_o,
  output tcon_pkg::tcon_out_t            result_o
);
  import tcon_pkg::*;

  localparam int NCells = ROWS * COLUMNS;
  localparam int AW     = $clog2(NCells);
  localparam int RW     = $clog2(ROWS);
  localparam int CW     = $clog2(COLUMNS);

  // Cell store.
  logic [15:0]        cells_q [NCells];
  logic [15:0]        rdata_q;

  tcon_in_t           item_q;
  logic [CfgDataW-1:0] fg_q, bg_q;
  logic [RW-1:0]      row_q, row_d;
  logic [CW-1:0]      col_q, col_d;
  logic [AW-1:0]      cnt_q;
  logic               cp_vld_q;
  logic [AW-1:0]      cp_addr_q;
  logic               scr_q;
  logic               done_q;
  tcon_out_t          result_q;

  logic [AW-1:0]      cur_idx;
  logic               row_last, col_last;
  logic               rd_ok;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [15:0]        wdata;
  logic               re;
  logic [AW-1:0]      raddr;

  // Cursor position and edge flags.
  assign cur_idx  = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
  assign row_last = (row_q == RW'(ROWS - 1));
  assign col_last = (col_q == CW'(COLUMNS - 1));
  assign rd_ok    = (32'(item_q.cell_address) < 32'(NCells));

  assign sts_o.command      = item_q.command;
  assign sts_o.is_newline   = (item_q.symbol == NewlineByte);
  assign sts_o.col_last     = col_last;
  assign sts_o.row_last     = row_last;
  assign sts_o.cnt_end      = (cnt_q == AW'(NCells - 1));
  assign sts_o.cnt_copy_end = (cnt_q == AW'(NCells - COLUMNS - 1));

  // Store write port: a pending scroll copy, a printed cell or a fill word.
  always_comb begin
    we    = 1'b0;
    waddr = cnt_q;
    wdata = '0;
    if (cp_vld_q) begin
      we    = 1'b1;
      waddr = cp_addr_q;
      wdata = rdata_q;
    end else if (cmd_i.wr_cursor) begin
      we    = 1'b1;
      waddr = cur_idx;
      wdata = {bg_q, fg_q, item_q.symbol};
    end else if (cmd_i.wr_fill) begin
      we    = 1'b1;
      waddr = cnt_q;
      wdata = cmd_i.fill_blank ? {bg_q, fg_q, SpaceByte} : 16'h0000;
    end
  end

  // Store read port: the item's cell, or the cell one row below for a scroll.
  always_comb begin
    re    = 1'b0;
    raddr = cnt_q + AW'(COLUMNS);
    if (cmd_i.rd_copy) begin
      re = 1'b1;
    end else if (cmd_i.rd_item && rd_ok) begin
      re    = 1'b1;
      raddr = AW'(item_q.cell_address);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      cells_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= cells_q[raddr];
    end
  end

  // Cursor update.
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cmd_i.cur_home) begin
      row_d = '0;
      col_d = '0;
    end else if (cmd_i.cur_newline) begin
      col_d = '0;
      if (!row_last) begin
        row_d = row_q + RW'(1);
      end
    end else if (cmd_i.cur_adv) begin
      col_d = col_q + CW'(1);
    end
  end

  // Control registers: cursor, colors, sweep counter, copy pipe, strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      col_q    <= '0;
      fg_q     <= FgReset;
      bg_q     <= BgReset;
      cnt_q    <= '0;
      cp_vld_q <= 1'b0;
      scr_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      row_q    <= row_d;
      col_q    <= col_d;
      cp_vld_q <= cmd_i.rd_copy;
      done_q   <= cmd_i.finish;
      if (cfg_we_i && cfg_idx_i == CfgFgIdx) begin
        fg_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == CfgBgIdx) begin
        bg_q <= cfg_data_i;
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + AW'(1);
      end
      if (cmd_i.cap) begin
        scr_q <= 1'b0;
      end else if (cmd_i.set_scroll) begin
        scr_q <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cp_addr_q <= cnt_q;
    if (cmd_i.cap) begin
      item_q <= item_i;
    end
    if (cmd_i.finish) begin
      result_q.cursor_position <= 11'(cur_idx);
      result_q.cell_data       <= (item_q.command == CmdRead && rd_ok) ? rdata_q : 16'h0000;
      result_q.scrolled        <= scr_q;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // A pending copy write never meets another write on the single port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cp_vld_q |-> !(cmd_i.wr_cursor || cmd_i.wr_fill))
    else $error("scroll copy write collides with another store write");

  // The cursor stays on the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= RW'(ROWS - 1)) && (col_q <= CW'(COLUMNS - 1)))
    else $error("cursor left the screen");

  // Every finish produces exactly one result strobe in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (done_q && !cmd_i.finish))
    else $error("finish did not give a single result strobe");

endmodule
`default_nettype wire

FILE: rtl/text_console_cursor_scroll_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console cursor and scroll unit
// Character-cell console with a cursor, print, clear and cell read commands.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its one result shows
// on result_o for a single cycle with done_o high and cannot be held off.
// After reset the store is swept to zeros with busy high. A print without
// scroll, a read or an unused command passes through the execute and finish
// states and the result strobe comes in the cycle busy falls. A clear and a
// print that scrolls also sweep the store with busy high: the store has one
// write and one read port, so the clear sweep writes one cell a cycle and the
// scroll copies one cell a cycle, then zeroes the bottom row. Color registers
// must be written only while busy is low; the block itself does not enforce
// this.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start,
  output logic                          busy,
  input  tcon_pkg::tcon_in_t            item_i,
  output logic                          done_o,
  output tcon_pkg::tcon_out_t           result_o,
  input  wire                           cfg_we_i,
  input  wire [tcon_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [tcon_pkg::CfgDataW-1:0]  cfg_data_i
);
  import tcon_pkg::*;

  tcon_cmd_t cmd;
  tcon_sts_t sts;

  // Sequencing.
  tcon_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Store, cursor and result.
  tcon_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .done_o     (done_o),
    .result_o   (result_o)
  );

endmodule
`default_nettype wire

FILE: tb/text_console_cursor_scroll_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor and scroll unit testbench
// Drives print, clear, read and unused command items through the start/busy
// handshake and predicts every result with a behavioral copy of the screen
// store, the cursor and the color registers. Covers the reset state, basic
// printing, line wrap, scrolling, clearing and random traffic under several
// color settings. Random idle gaps are inserted on the sending side.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_unit_tb;
  import tcon_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  // A clear or a scroll walks the whole store; this is several times that.
  localparam int QUIET_LIMIT = 20000;
  // Command code that the block does not use.
  localparam logic [1:0] CmdUnused = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  tcon_in_t            item_i;
  logic                done_o;
  tcon_out_t           result_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Behavioral copy of the console state.
  logic [15:0]   screen_model [CELLS];
  int            cur_row;
  int            cur_col;
  logic [3:0]    fg_color;
  logic [3:0]    bg_color;

  tcon_out_t     pending_results [$];
  tcon_out_t     want;
  int            mismatches;
  logic          idle_en;

  text_console_cursor_scroll_unit #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .item_i    (item_i),
    .done_o    (done_o),
    .result_o  (result_o),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Move the cursor to the start of the next row, scrolling on the last row.
  function automatic logic next_row();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) begin
        screen_model[i] = screen_model[i + COLUMNS];
      end
      for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
        screen_model[i] = '0;
      end
      cur_row = ROWS - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one item to the model and return the result it should produce.
  function automatic tcon_out_t console_step(tcon_in_t it);
    tcon_out_t r;
    logic      sc;
    int        pos;
    r  = '0;
    sc = 1'b0;
    case (it.command)
      CmdPrint: begin
        if (it.symbol == NewlineByte) begin
          sc = next_row();
        end else begin
          screen_model[cur_row * COLUMNS + cur_col] = {bg_color, fg_color, it.symbol};
          cur_col++;
          if (cur_col >= COLUMNS) sc = next_row();
        end
      end
      CmdClear: begin
        for (int i = 0; i < CELLS; i++) begin
          screen_model[i] = {bg_color, fg_color, SpaceByte};
        end
        cur_row = 0;
        cur_col = 0;
      end
      CmdRead: begin
        if (it.cell_address < CELLS) r.cell_data = screen_model[it.cell_address];
      end
      default: begin
      end
    endcase
    pos               = cur_row * COLUMNS + cur_col;
    r.cursor_position = pos[10:0];
    r.scrolled        = sc;
    return r;
  endfunction

  function automatic tcon_in_t make_item(logic [1:0] cmd, logic [7:0] sym, logic [10:0] addr);
    tcon_in_t it;
    it.command      = cmd;
    it.symbol       = sym;
    it.cell_address = addr;
    return it;
  endfunction

  // Any printable byte, that is anything but a newline.
  function automatic logic [7:0] text_byte();
    logic [7:0] s;
    do s = 8'($urandom_range(255)); while (s == NewlineByte);
    return s;
  endfunction

  function automatic logic [10:0] rand_addr();
    return 11'($urandom_range(2047));
  endfunction

  // Send one item, with a random idle gap first, and record its prediction.
  task automatic send_item(tcon_in_t it);
    if (idle_en) begin
      while ($urandom_range(99) < 24) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(console_step(it));
  endtask

  // Hold off the sender until the block is idle and every result is in.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (busy || pending_results.size() != 0);
  endtask

  // Write both color registers while the block is idle.
  task automatic set_colors(logic [3:0] fg, logic [3:0] bg);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgFgIdx;
    cfg_data_i <= fg;
    @(posedge clk_i);
    fg_color   = fg;
    cfg_idx_i  <= CfgBgIdx;
    cfg_data_i <= bg;
    @(posedge clk_i);
    bg_color   = bg;
    cfg_we_i   <= 1'b0;
  endtask

  // The store must read back as zeros after reset, in range or not.
  task automatic test_reset_state();
    send_item(make_item(CmdRead, 8'h00, 11'd0));
    send_item(make_item(CmdRead, 8'hFF, 11'd1999));
    send_item(make_item(CmdRead, 8'h00, 11'd2000));
    send_item(make_item(CmdRead, 8'hFF, 11'd2047));
    // Reset colors are used until the registers are first written.
    send_item(make_item(CmdPrint, 8'h7E, 11'd0));
    send_item(make_item(CmdRead, 8'h00, 11'd0));
  endtask

  // Printing of the extreme symbols, a newline and read-back of the cells.
  task automatic test_print_basics();
    set_colors(4'd0, 4'd15);
    send_item(make_item(CmdPrint, 8'h41, 11'h7FF));
    send_item(make_item(CmdPrint, 8'h00, 11'd0));
    send_item(make_item(CmdPrint, 8'hFF, 11'd5));
    send_item(make_item(CmdPrint, NewlineByte, 11'd0));
    send_item(make_item(CmdPrint, SpaceByte, 11'd0));
    send_item(make_item(CmdRead, 8'h00, 11'd1));
    send_item(make_item(CmdRead, 8'h00, 11'd2));
    send_item(make_item(CmdRead, 8'h00, 11'd3));
    send_item(make_item(CmdRead, 8'h00, 11'd80));
  endtask

  // The unused command must leave everything as it was.
  task automatic test_unused_command();
    send_item(make_item(CmdUnused, 8'hFF, 11'h7FF));
    send_item(make_item(CmdUnused, 8'h00, 11'd0));
  endtask

  // Clear fills the store with blanks in the current colors and homes.
  task automatic test_clear();
    set_colors(4'd15, 4'd15);
    send_item(make_item(CmdClear, 8'hFF, 11'h7FF));
    send_item(make_item(CmdRead, 8'h00, 11'd0));
    send_item(make_item(CmdRead, 8'h00, 11'd1999));
    send_item(make_item(CmdRead, 8'h00, 11'd2047));
    send_item(make_item(CmdPrint, 8'h55, 11'd0));
    send_item(make_item(CmdRead, 8'h00, 11'd0));
  endtask

  // Lines of text without idle gaps, long enough to wrap and to scroll.
  task automatic test_line_scroll();
    int n;
    int len;
    idle_en = 1'b0;
    n       = 0;
    set_colors(4'($urandom_range(15)), 4'($urandom_range(15)));
    repeat (18) begin
      send_item(make_item(CmdPrint, NewlineByte, rand_addr()));
      n++;
    end
    while (n < 340) begin
      len = ($urandom_range(99) < 85) ? $urandom_range(4) : $urandom_range(84, 76);
      repeat (len) begin
        send_item(make_item(CmdPrint, text_byte(), rand_addr()));
        n++;
      end
      send_item(make_item(CmdPrint, NewlineByte, rand_addr()));
      // Check the row above the cursor and the bottom row after the move.
      if (cur_row > 0) begin
        send_item(make_item(CmdRead, text_byte(),
                            11'((cur_row - 1) * COLUMNS + $urandom_range(COLUMNS - 1))));
      end
      send_item(make_item(CmdRead, text_byte(),
                          11'((ROWS - 1) * COLUMNS + $urandom_range(COLUMNS - 1))));
      n += 3;
    end
    idle_en = 1'b1;
  endtask

  // Mixed random traffic, mostly text with reads of written cells.
  task automatic test_random_mix(logic [3:0] fg, logic [3:0] bg, int count);
    int r;
    int pos;
    set_colors(fg, bg);
    repeat (count) begin
      r   = $urandom_range(99);
      pos = cur_row * COLUMNS + cur_col;
      if (r < 50) begin
        send_item(make_item(CmdPrint, text_byte(), rand_addr()));
      end else if (r < 62) begin
        send_item(make_item(CmdPrint, NewlineByte, rand_addr()));
      end else if (r < 73) begin
        send_item(make_item(CmdRead, 8'($urandom_range(255)), 11'($urandom_range(pos))));
      end else if (r < 82) begin
        send_item(make_item(CmdRead, 8'($urandom_range(255)), rand_addr()));
      end else if (r < 83) begin
        send_item(make_item(CmdClear, 8'($urandom_range(255)), rand_addr()));
      end else if (r < 89) begin
        send_item(make_item(CmdUnused, 8'($urandom_range(255)), rand_addr()));
      end else begin
        send_item(make_item(CmdPrint, 8'($urandom_range(255)), rand_addr()));
      end
    end
  endtask

  // Compare every result with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, got %h", $time, result_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (result_o.cursor_position !== want.cursor_position) begin
          $display("%0t: cursor_position expected %0d, got %0d", $time,
                   want.cursor_position, result_o.cursor_position);
          mismatches++;
        end
        if (result_o.cell_data !== want.cell_data) begin
          $display("%0t: cell_data expected %h, got %h", $time,
                   want.cell_data, result_o.cell_data);
          mismatches++;
        end
        if (result_o.scrolled !== want.scrolled) begin
          $display("%0t: scrolled expected %b, got %b", $time,
                   want.scrolled, result_o.scrolled);
          mismatches++;
        end
      end
    end
  end

  // End the run if nothing moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || done_o) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Reset, then the tests in turn, then the final verdict.
  initial begin
    rst_ni     = 1'b0;
    start      = 1'b0;
    item_i     = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    idle_en    = 1'b1;
    mismatches = 0;
    cur_row    = 0;
    cur_col    = 0;
    fg_color   = FgReset;
    bg_color   = BgReset;
    for (int i = 0; i < CELLS; i++) screen_model[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_print_basics();
    test_unused_command();
    test_clear();
    test_line_scroll();
    test_random_mix(4'd0, 4'd0, 160);
    test_random_mix(4'd15, 4'd15, 160);
    test_random_mix(4'($urandom_range(15)), 4'($urandom_range(15)), 160);
    test_random_mix(4'd15, 4'd0, 160);
    test_random_mix(4'($urandom_range(15)), 4'($urandom_range(15)), 160);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
